>>> sv/owbs_pkg.sv
// Package for the one-wire backlight serializer: shared types, register
// indexes, command codes and the level-to-raw brightness table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package owbs_pkg;

    // Field widths
    localparam int DUR_W   = 13;   // long segment durations
    localparam int PUL_W   = 8;    // bit pulse durations and address byte
    localparam int RAW_W   = 5;    // raw brightness code
    localparam int LEVEL_W = 4;
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_OFF  = 2'd2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_SHUTDOWN     = 3'd0;
    localparam logic [IDX_W-1:0] REG_OFF_HOLD     = 3'd1;
    localparam logic [IDX_W-1:0] REG_DETECT_DELAY = 3'd2;
    localparam logic [IDX_W-1:0] REG_DETECT_TIME  = 3'd3;
    localparam logic [IDX_W-1:0] REG_DETECT_WIN   = 3'd4;
    localparam logic [IDX_W-1:0] REG_SHORT        = 3'd5;
    localparam logic [IDX_W-1:0] REG_LONG         = 3'd6;
    localparam logic [IDX_W-1:0] REG_ADDRESS      = 3'd7;

    // Highest entry of the brightness table
    localparam logic [LEVEL_W-1:0] TABLE_LAST = 4'd9;

    // Classified request handed from front to back
    typedef enum logic [1:0] {
        OP_TICK,
        OP_SET,
        OP_OFF,
        OP_NOP
    } t_op_kind;

    typedef struct packed {
        t_op_kind         kind;
        logic [RAW_W-1:0] raw;
    } t_op;

    // Configuration register file
    typedef struct packed {
        logic [DUR_W-1:0] shutdown_us;
        logic [DUR_W-1:0] off_hold_us;
        logic [DUR_W-1:0] detect_delay_us;
        logic [DUR_W-1:0] detect_time_us;
        logic [DUR_W-1:0] detect_window_us;
        logic [PUL_W-1:0] short_us;
        logic [PUL_W-1:0] long_us;
        logic [PUL_W-1:0] device_address;
    } t_cfg;

    // Level to raw brightness; anything past the last entry reads the last
    function automatic logic [RAW_W-1:0] level_map(input logic [LEVEL_W-1:0] lvl);
        logic [RAW_W-1:0] raw;
        case (lvl)
            4'd0:    raw = 5'd0;
            4'd1:    raw = 5'd1;
            4'd2:    raw = 5'd4;
            4'd3:    raw = 5'd8;
            4'd4:    raw = 5'd12;
            4'd5:    raw = 5'd16;
            4'd6:    raw = 5'd20;
            4'd7:    raw = 5'd24;
            4'd8:    raw = 5'd28;
            default: raw = 5'd31;
        endcase
        return raw;
    endfunction

endpackage

`default_nettype wire

>>> sv/one_wire_backlight_serializer.sv
// Top level of the one-wire backlight serializer: configuration registers,
// front classifier, request queue and back sequencer.
// Depends on owbs_pkg, owbs_front, owbs_queue, owbs_back.
`timescale 1ns / 1ps
`default_nettype none

// Every input request (a one-microsecond tick, a set-level or an off command)
// yields exactly one result: the wire level, busy, and whether a command was
// turned away because a sequence was still running. One request is taken
// per clock cycle in steady state while the result channel is ready; a
// request goes through the front register, the four-entry queue and the
// sequencer's result register. Each stage stalls on its own, so a held-off
// result slot only stops input once the queue has filled.
// Configuration registers are written through a plain write port and must
// only change while no request is in flight.

module one_wire_backlight_serializer #(
    parameter int PASSES    = 2,
    parameter int MAX_LEVEL = 9
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // configuration
    input  wire                          i_cfg_we,
    input  wire  [owbs_pkg::IDX_W-1:0]   i_cfg_idx,
    input  wire  [owbs_pkg::DUR_W-1:0]   i_cfg_wdata,
    // request channel
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire  [owbs_pkg::CMD_W-1:0]   i_command,
    input  wire  [owbs_pkg::LEVEL_W-1:0] i_level,
    // result channel
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic                         o_line,
    output logic                         o_busy_res,
    output logic                         o_rejected
);
    import owbs_pkg::*;

    t_cfg r_cfg;
    logic w_f_valid, w_f_ready;
    t_op  w_f_op;
    logic w_q_valid, w_q_ready;
    t_op  w_q_op;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shutdown_us      <= 13'd3000;
            r_cfg.off_hold_us      <= 13'd5000;
            r_cfg.detect_delay_us  <= 13'd200;
            r_cfg.detect_time_us   <= 13'd500;
            r_cfg.detect_window_us <= 13'd1000;
            r_cfg.short_us         <= 8'd10;
            r_cfg.long_us          <= 8'd50;
            r_cfg.device_address   <= 8'h72;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SHUTDOWN:     r_cfg.shutdown_us      <= i_cfg_wdata;
                REG_OFF_HOLD:     r_cfg.off_hold_us      <= i_cfg_wdata;
                REG_DETECT_DELAY: r_cfg.detect_delay_us  <= i_cfg_wdata;
                REG_DETECT_TIME:  r_cfg.detect_time_us   <= i_cfg_wdata;
                REG_DETECT_WIN:   r_cfg.detect_window_us <= i_cfg_wdata;
                REG_SHORT:        r_cfg.short_us         <= i_cfg_wdata[PUL_W-1:0];
                REG_LONG:         r_cfg.long_us          <= i_cfg_wdata[PUL_W-1:0];
                REG_ADDRESS:      r_cfg.device_address   <= i_cfg_wdata[PUL_W-1:0];
                default:          r_cfg                  <= r_cfg;
            endcase
        end
    end

    // Accept and classify
    owbs_front #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_command  (i_command),
        .i_level    (i_level),
        .o_op_valid (w_f_valid),
        .i_op_ready (w_f_ready),
        .o_op       (w_f_op)
    );

    // Decoupling queue
    owbs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_op    (w_f_op),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_op     (w_q_op)
    );

    // Line sequencer and result register
    owbs_back #(
        .PASSES (PASSES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_op_valid  (w_q_valid),
        .o_op_ready  (w_q_ready),
        .i_op        (w_q_op),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_line      (o_line),
        .o_busy_res  (o_busy_res),
        .o_rejected  (o_rejected)
    );

endmodule

`default_nettype wire

>>> sv/owbs_front.sv
// Front stage of the one-wire backlight serializer: accepts input requests,
// clamps and maps the level, and holds one classified request for the queue.
// Depends on owbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module owbs_front #(
    parameter int MAX_LEVEL = 9
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire  [owbs_pkg::CMD_W-1:0]   i_command,
    input  wire  [owbs_pkg::LEVEL_W-1:0] i_level,
    output logic                         o_op_valid,
    input  wire                          i_op_ready,
    output owbs_pkg::t_op                o_op
);
    import owbs_pkg::*;

    localparam logic [LEVEL_W-1:0] LP_MAX = LEVEL_W'(MAX_LEVEL);

    logic             r_valid;
    t_op              r_op;
    t_op              n_op;
    logic [LEVEL_W-1:0] w_lvl;
    logic             w_take;

    // Clamp to the configured maximum, then to the table end
    always_comb begin
        w_lvl = (i_level > LP_MAX) ? LP_MAX : i_level;
        if (w_lvl > TABLE_LAST) begin
            w_lvl = TABLE_LAST;
        end
    end

    // Classify the command
    always_comb begin
        n_op.raw = level_map(w_lvl);
        case (i_command)
            CMD_TICK: n_op.kind = OP_TICK;
            CMD_SET:  n_op.kind = OP_SET;
            CMD_OFF:  n_op.kind = OP_OFF;
            default:  n_op.kind = OP_NOP;
        endcase
    end

    assign o_in_ready = !r_valid || i_op_ready;
    assign w_take     = i_in_valid && o_in_ready;

    // Holding register toward the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
        if (w_take) begin
            r_op <= n_op;
        end
    end

    assign o_op_valid = r_valid;
    assign o_op       = r_op;

endmodule

`default_nettype wire

>>> sv/owbs_queue.sv
// Short request queue between the front and back stages of the one-wire
// backlight serializer. Depends on owbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module owbs_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push_valid,
    output logic           o_push_ready,
    input  owbs_pkg::t_op  i_push_op,
    output logic           o_pop_valid,
    input  wire            i_pop_ready,
    output owbs_pkg::t_op  o_pop_op
);
    import owbs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] LP_DEPTH = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LP_LAST  = PTR_W'(QUEUE_DEPTH - 1);

    t_op              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != LP_DEPTH);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_op     = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_op;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LP_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LP_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/owbs_back.sv
// Back stage of the one-wire backlight serializer: the line sequencer that
// runs the off hold, or shutdown, detect and the two pulse-width bytes, plus
// the result register. Depends on owbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module owbs_back #(
    parameter int PASSES = 2
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  owbs_pkg::t_cfg i_cfg,
    input  wire            i_op_valid,
    output logic           o_op_ready,
    input  owbs_pkg::t_op  i_op,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output logic           o_line,
    output logic           o_busy_res,
    output logic           o_rejected
);
    import owbs_pkg::*;

    localparam int PW  = (PASSES > 1) ? $clog2(PASSES) : 1;
    localparam int PW1 = PW + 1;
    localparam logic [PW:0] LP_PASSES = PW1'(PASSES);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_OFF,
        PH_SHUT,
        PH_DDELAY,
        PH_DTIME,
        PH_DWIN,
        PH_START,
        PH_BLOW,
        PH_BHIGH,
        PH_END
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [DUR_W-1:0] r_rem, n_rem;
    logic [2:0]       r_bit, n_bit;
    logic             r_data, n_data;
    logic [PW-1:0]    r_pass, n_pass;
    logic [7:0]       r_shift, n_shift;
    logic [RAW_W-1:0] r_raw, n_raw;
    logic             r_line, n_line;
    logic             r_out_valid, n_out_valid;
    logic             r_busy, r_rej, n_rej;
    logic             w_pop;
    logic             w_busy;
    logic [7:0]       w_shifted;
    logic [PW:0]      w_pass_inc;
    logic [DUR_W-1:0] w_short;
    logic [DUR_W-1:0] w_long;

    assign w_pop      = i_op_valid && (!r_out_valid || i_out_ready);
    assign o_op_ready = w_pop;
    assign w_busy     = (r_phase != PH_IDLE);
    assign w_shifted  = {r_shift[6:0], 1'b0};
    assign w_pass_inc = {1'b0, r_pass} + 1'b1;
    assign w_short    = DUR_W'(i_cfg.short_us);
    assign w_long     = DUR_W'(i_cfg.long_us);

    // Next state of the sequencer for one request
    always_comb begin
        n_phase = r_phase;
        n_rem   = r_rem;
        n_bit   = r_bit;
        n_data  = r_data;
        n_pass  = r_pass;
        n_shift = r_shift;
        n_raw   = r_raw;
        n_line  = r_line;
        n_rej   = 1'b0;
        if (w_pop) begin
            case (i_op.kind)
                OP_TICK: begin
                    if (w_busy && r_rem > DUR_W'(1)) begin
                        n_rem = r_rem - 1'b1;
                    end else if (w_busy) begin
                        // segment done: move on and drive the next level
                        unique case (r_phase)
                            PH_OFF: begin
                                n_phase = PH_IDLE;
                                n_rem   = '0;
                            end
                            PH_SHUT: begin
                                n_phase = PH_DDELAY;
                                n_line  = 1'b1;
                                n_rem   = i_cfg.detect_delay_us;
                            end
                            PH_DDELAY: begin
                                n_phase = PH_DTIME;
                                n_line  = 1'b0;
                                n_rem   = i_cfg.detect_time_us;
                            end
                            PH_DTIME: begin
                                n_phase = PH_DWIN;
                                n_line  = 1'b1;
                                n_rem   = i_cfg.detect_window_us;
                            end
                            PH_DWIN: begin
                                n_data  = 1'b0;
                                n_shift = i_cfg.device_address;
                                n_bit   = '0;
                                n_phase = PH_START;
                                n_line  = 1'b1;
                                n_rem   = w_short;
                            end
                            PH_START: begin
                                n_phase = PH_BLOW;
                                n_line  = 1'b0;
                                n_rem   = r_shift[7] ? w_short : w_long;
                            end
                            PH_BLOW: begin
                                n_phase = PH_BHIGH;
                                n_line  = 1'b1;
                                n_rem   = r_shift[7] ? w_long : w_short;
                            end
                            PH_BHIGH: begin
                                n_shift = w_shifted;
                                n_line  = 1'b0;
                                if (r_bit == 3'd7) begin
                                    n_bit   = '0;
                                    n_phase = PH_END;
                                    n_rem   = w_short;
                                end else begin
                                    n_bit   = r_bit + 1'b1;
                                    n_phase = PH_BLOW;
                                    n_rem   = w_shifted[7] ? w_short : w_long;
                                end
                            end
                            PH_END: begin
                                if (!r_data) begin
                                    // address done, data byte follows
                                    n_data  = 1'b1;
                                    n_shift = 8'(r_raw);
                                    n_bit   = '0;
                                    n_phase = PH_START;
                                    n_line  = 1'b1;
                                    n_rem   = w_short;
                                end else if (w_pass_inc < LP_PASSES) begin
                                    n_data  = 1'b0;
                                    n_pass  = w_pass_inc[PW-1:0];
                                    n_phase = PH_SHUT;
                                    n_line  = 1'b0;
                                    n_rem   = i_cfg.shutdown_us;
                                end else begin
                                    n_data  = 1'b0;
                                    n_pass  = '0;
                                    n_phase = PH_IDLE;
                                    n_rem   = '0;
                                    n_line  = 1'b1;
                                end
                            end
                            default: begin
                                n_phase = PH_IDLE;
                                n_rem   = '0;
                            end
                        endcase
                    end
                end
                OP_SET: begin
                    if (w_busy) begin
                        n_rej = 1'b1;
                    end else begin
                        n_raw   = i_op.raw;
                        n_pass  = '0;
                        n_data  = 1'b0;
                        n_bit   = '0;
                        n_phase = PH_SHUT;
                        n_line  = 1'b0;
                        n_rem   = i_cfg.shutdown_us;
                    end
                end
                OP_OFF: begin
                    if (w_busy) begin
                        n_rej = 1'b1;
                    end else begin
                        n_phase = PH_OFF;
                        n_line  = 1'b0;
                        n_rem   = i_cfg.off_hold_us;
                    end
                end
                default: begin
                    n_rej = 1'b0;
                end
            endcase
        end
    end

    // Result slot: filled on every processed request, freed when taken
    always_comb begin
        if (w_pop) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Sequencer state and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_rem       <= '0;
            r_bit       <= '0;
            r_data      <= 1'b0;
            r_pass      <= '0;
            r_shift     <= '0;
            r_raw       <= '0;
            r_line      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_rem       <= n_rem;
            r_bit       <= n_bit;
            r_data      <= n_data;
            r_pass      <= n_pass;
            r_shift     <= n_shift;
            r_raw       <= n_raw;
            r_line      <= n_line;
            r_out_valid <= n_out_valid;
        end
        if (w_pop) begin
            r_busy <= (n_phase != PH_IDLE);
            r_rej  <= n_rej;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_line      = r_line;
    assign o_busy_res  = r_busy;
    assign o_rejected  = r_rej;

endmodule

`default_nettype wire

>>> sim/one_wire_backlight_serializer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for one_wire_backlight_serializer. It predicts the
// wire, busy and reject result of every request and compares them in order.
// Depends on owbs_pkg and the serializer RTL.

module one_wire_backlight_serializer_tb;
    import owbs_pkg::*;

    localparam int PASSES          = 2;
    localparam int MAX_LEVEL       = 9;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES    = 1_500_000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_CYCLES     = 300;
    localparam int IDLE_PCT        = 36;
    localparam int RANDOM_PHASES   = 4;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int REPORT_MAX      = 10;

    // raw brightness per clamped level, entry 0 in the low bits
    localparam logic [10*RAW_W-1:0] RAW_TABLE = {
        5'd31, 5'd28, 5'd24, 5'd20, 5'd16, 5'd12, 5'd8, 5'd4, 5'd1, 5'd0
    };

    typedef enum logic [3:0] {
        S_IDLE, S_OFF, S_SHUT, S_DDELAY, S_DTIME, S_DWIN,
        S_START, S_BLOW, S_BHIGH, S_END
    } t_seq_state;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [LEVEL_W-1:0] lvl;
    } t_request;

    typedef struct packed {
        logic line;
        logic busy;
        logic rejected;
    } t_wire_result;

    // DUT connections
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [IDX_W-1:0]   i_cfg_idx   = '0;
    logic [DUR_W-1:0]   i_cfg_wdata = '0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic [CMD_W-1:0]   i_command   = CMD_TICK;
    logic [LEVEL_W-1:0] i_level     = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_line;
    logic               o_busy_res;
    logic               o_rejected;

    one_wire_backlight_serializer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_level     (i_level),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_line      (o_line),
        .o_busy_res  (o_busy_res),
        .o_rejected  (o_rejected)
    );

    // Predicted sequencer state and register copy
    t_seq_state         sq_state     = S_IDLE;
    logic [DUR_W-1:0]   seg_left     = '0;
    logic [2:0]         bit_idx      = '0;
    logic               in_data_byte = 1'b0;
    int                 pass_idx     = 0;
    logic [7:0]         shift_reg    = '0;
    logic [RAW_W-1:0]   raw_code     = '0;
    logic               line_lvl     = 1'b1;
    logic [DUR_W-1:0]   cfg_reg [8];

    t_request           req_backlog[$];
    t_wire_result       wire_expect_q[$];

    bit                 quiet        = 1'b0;
    bit                 hold_request = 1'b0;
    bit                 hold_done    = 1'b0;
    int                 hold_left    = 0;
    int                 fail_count   = 0;
    int                 cycle_count  = 0;

    // Clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ---------------- prediction ----------------

    function automatic void enter_segment(input t_seq_state s, input logic lvl,
                                          input logic [DUR_W-1:0] dur);
        sq_state = s;
        line_lvl = lvl;
        seg_left = dur;
    endfunction

    // bit halves follow the current MSB: one is short low, long high
    function automatic logic [DUR_W-1:0] low_half();
        return shift_reg[7] ? cfg_reg[REG_SHORT] : cfg_reg[REG_LONG];
    endfunction

    function automatic logic [DUR_W-1:0] high_half();
        return shift_reg[7] ? cfg_reg[REG_LONG] : cfg_reg[REG_SHORT];
    endfunction

    function automatic void start_byte(input logic [7:0] value, input logic is_data);
        in_data_byte = is_data;
        shift_reg    = value;
        bit_idx      = '0;
        enter_segment(S_START, 1'b1, cfg_reg[REG_SHORT]);
    endfunction

    // segment exhausted: move to the next one
    function automatic void advance_segment();
        case (sq_state)
            S_SHUT:   enter_segment(S_DDELAY, 1'b1, cfg_reg[REG_DETECT_DELAY]);
            S_DDELAY: enter_segment(S_DTIME, 1'b0, cfg_reg[REG_DETECT_TIME]);
            S_DTIME:  enter_segment(S_DWIN, 1'b1, cfg_reg[REG_DETECT_WIN]);
            S_DWIN:   start_byte(cfg_reg[REG_ADDRESS][7:0], 1'b0);
            S_START:  enter_segment(S_BLOW, 1'b0, low_half());
            S_BLOW:   enter_segment(S_BHIGH, 1'b1, high_half());
            S_BHIGH: begin
                shift_reg = shift_reg << 1;
                if (bit_idx == 3'd7) begin
                    bit_idx = '0;
                    enter_segment(S_END, 1'b0, cfg_reg[REG_SHORT]);
                end else begin
                    bit_idx = bit_idx + 3'd1;
                    enter_segment(S_BLOW, 1'b0, low_half());
                end
            end
            S_END: begin
                if (!in_data_byte) begin
                    start_byte({3'b000, raw_code}, 1'b1);
                end else begin
                    in_data_byte = 1'b0;
                    pass_idx++;
                    if (pass_idx < PASSES) begin
                        // next pass drops straight to shutdown low
                        enter_segment(S_SHUT, 1'b0, cfg_reg[REG_SHUTDOWN]);
                    end else begin
                        pass_idx = 0;
                        sq_state = S_IDLE;
                        seg_left = '0;
                        line_lvl = 1'b1;
                    end
                end
            end
            default: begin
                // off hold done: line stays low
                sq_state = S_IDLE;
                seg_left = '0;
            end
        endcase
    endfunction

    function automatic t_wire_result serializer_step(input logic [CMD_W-1:0] cmd,
                                                     input logic [LEVEL_W-1:0] lvl);
        t_wire_result res;
        logic [LEVEL_W-1:0] pick;
        logic running;
        res.rejected = 1'b0;
        running = (sq_state != S_IDLE);
        pick = lvl;
        if (cmd == CMD_TICK) begin
            if (running) begin
                // zero-length segment behaves as one tick
                if (seg_left <= 1)
                    advance_segment();
                else
                    seg_left = seg_left - 1'b1;
            end
        end else if (cmd == CMD_SET || cmd == CMD_OFF) begin
            if (running) begin
                res.rejected = 1'b1;
            end else if (cmd == CMD_SET) begin
                if (pick > LEVEL_W'(MAX_LEVEL))
                    pick = LEVEL_W'(MAX_LEVEL);
                if (pick > TABLE_LAST)
                    pick = TABLE_LAST;
                raw_code     = RAW_TABLE[pick*RAW_W +: RAW_W];
                pass_idx     = 0;
                in_data_byte = 1'b0;
                bit_idx      = '0;
                enter_segment(S_SHUT, 1'b0, cfg_reg[REG_SHUTDOWN]);
            end else begin
                enter_segment(S_OFF, 1'b0, cfg_reg[REG_OFF_HOLD]);
            end
        end
        res.line = line_lvl;
        res.busy = (sq_state != S_IDLE);
        return res;
    endfunction

    // ---------------- request driver ----------------

    always @(posedge i_clk) begin : drive_requests
        t_request nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                wire_expect_q.push_back(serializer_step(i_command, i_level));
            if (!i_in_valid || o_in_ready) begin
                if (req_backlog.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = req_backlog.pop_front();
                    i_in_valid <= 1'b1;
                    i_command  <= nxt.cmd;
                    i_level    <= nxt.lvl;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- result receiver ----------------

    // random stalls, plus one long hold-off counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic flag_result(input string what, input t_wire_result want);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%0t: %s: expected line=%0b busy=%0b rej=%0b, got line=%0b busy=%0b rej=%0b",
                     $realtime, what, want.line, want.busy, want.rejected,
                     o_line, o_busy_res, o_rejected);
    endtask

    // compare every result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_wire_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (wire_expect_q.size() == 0) begin
                want = '0;
                flag_result("result with no request pending", want);
            end else begin
                want = wire_expect_q.pop_front();
                if (o_line !== want.line || o_busy_res !== want.busy ||
                    o_rejected !== want.rejected)
                    flag_result("mismatch", want);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    task automatic queue_req(input logic [CMD_W-1:0] cmd, input logic [LEVEL_W-1:0] lvl);
        t_request r;
        r.cmd = cmd;
        r.lvl = lvl;
        req_backlog.push_back(r);
    endtask

    // wait until every request has been taken and answered
    task automatic drain_pipeline();
        @(negedge i_clk);
        while (req_backlog.size() != 0 || i_in_valid || wire_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // feed ticks until the running sequence is over
    task automatic run_to_idle();
        drain_pipeline();
        while (sq_state != S_IDLE) begin
            if (req_backlog.size() < 2)
                queue_req(CMD_TICK, LEVEL_W'($urandom));
            @(negedge i_clk);
        end
        drain_pipeline();
    endtask

    task automatic program_timing(input logic [DUR_W-1:0] shut, off_hold, ddly, dtim, dwin,
                                  input logic [DUR_W-1:0] shrt, lng, addr);
        logic [DUR_W-1:0] vals [8];
        vals[REG_SHUTDOWN]     = shut;
        vals[REG_OFF_HOLD]     = off_hold;
        vals[REG_DETECT_DELAY] = ddly;
        vals[REG_DETECT_TIME]  = dtim;
        vals[REG_DETECT_WIN]   = dwin;
        vals[REG_SHORT]        = shrt;
        vals[REG_LONG]         = lng;
        vals[REG_ADDRESS]      = addr;
        for (int r = 0; r < 8; r++) begin
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= IDX_W'(r);
            i_cfg_wdata <= vals[r];
            // pulse and address registers keep only eight bits
            cfg_reg[r] = (IDX_W'(r) >= REG_SHORT) ? {5'b00000, vals[r][7:0]} : vals[r];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [DUR_W-1:0] rand_dur();
        if ($urandom_range(7) == 0)
            return '0;
        if ($urandom_range(7) == 0)
            return DUR_W'($urandom_range(4, 40));
        return DUR_W'($urandom_range(1, 3));
    endfunction

    // upper bits are junk the register must drop
    function automatic logic [DUR_W-1:0] rand_pulse();
        return {5'($urandom), ($urandom_range(5) == 0) ? 8'd0 : 8'($urandom_range(1, 3))};
    endfunction

    function automatic int ticks_of(input logic [DUR_W-1:0] d);
        return (d == 0) ? 1 : int'(d);
    endfunction

    function automatic int set_sequence_ticks();
        int s;
        int l;
        s = ticks_of(cfg_reg[REG_SHORT]);
        l = ticks_of(cfg_reg[REG_LONG]);
        return PASSES * (ticks_of(cfg_reg[REG_SHUTDOWN]) + ticks_of(cfg_reg[REG_DETECT_DELAY])
                         + ticks_of(cfg_reg[REG_DETECT_TIME]) + ticks_of(cfg_reg[REG_DETECT_WIN])
                         + 2 * (2 * s + 8 * (s + l)));
    endfunction

    initial begin : stimulus
        int n;
        int k;
        int burst;
        bit paused;
        cfg_reg[REG_SHUTDOWN]     = 13'd3000;
        cfg_reg[REG_OFF_HOLD]     = 13'd5000;
        cfg_reg[REG_DETECT_DELAY] = 13'd200;
        cfg_reg[REG_DETECT_TIME]  = 13'd500;
        cfg_reg[REG_DETECT_WIN]   = 13'd1000;
        cfg_reg[REG_SHORT]        = 13'd10;
        cfg_reg[REG_LONG]         = 13'd50;
        cfg_reg[REG_ADDRESS]      = 13'h72;
        paused = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // after reset: idle ticks and the unused code change nothing
        queue_req(CMD_TICK, 4'hf);
        queue_req(CMD_UNUSED, 4'hf);
        queue_req(CMD_TICK, 4'h0);
        drain_pipeline();

        // short timing, levels across the table and past its end, commands while busy
        program_timing(13'd3, 13'd2, 13'd1, 13'd2, 13'd1, 13'd1, 13'd2, 13'h0a5);
        for (int lvl = 0; lvl < 16; lvl += 5) begin
            queue_req(CMD_SET, LEVEL_W'(lvl));
            if (lvl % 10 == 0) begin
                repeat (5) queue_req(CMD_TICK, 4'ha);
                queue_req(CMD_OFF, 4'h3);
                queue_req(CMD_SET, 4'h5);
                queue_req(CMD_UNUSED, 4'hc);
            end
            run_to_idle();
        end
        queue_req(CMD_OFF, 4'h0);
        queue_req(CMD_TICK, 4'h0);
        queue_req(CMD_SET, 4'h7);
        run_to_idle();

        // all-zero registers: every segment one tick
        program_timing('0, '0, '0, '0, '0, '0, '0, '0);
        queue_req(CMD_SET, 4'h9);
        run_to_idle();
        queue_req(CMD_OFF, 4'h1);
        run_to_idle();

        // random timing, mostly whole set and off sequences
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            program_timing(rand_dur(), rand_dur(), rand_dur(), rand_dur(), rand_dur(),
                           rand_pulse(), rand_pulse(), {5'($urandom), 8'($urandom)});
            quiet = (p == 2);
            if (p == 0)
                hold_request = 1'b1;
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                k = $urandom_range(99);
                if (k < 60) begin
                    queue_req(CMD_SET, LEVEL_W'($urandom));
                    n++;
                    // end the burst near the sequence end, either side of it
                    burst = set_sequence_ticks() - 6 + $urandom_range(0, 10);
                    for (int j = 0; j < burst; j++) begin
                        if ($urandom_range(49) == 0)
                            queue_req(CMD_W'($urandom), LEVEL_W'($urandom));
                        else
                            queue_req(CMD_TICK, LEVEL_W'($urandom));
                        n++;
                    end
                end else if (k < 80) begin
                    queue_req(CMD_OFF, LEVEL_W'($urandom));
                    n++;
                    burst = ticks_of(cfg_reg[REG_OFF_HOLD]) - 2 + $urandom_range(0, 4);
                    for (int j = 0; j < burst; j++) begin
                        queue_req(CMD_TICK, LEVEL_W'($urandom));
                        n++;
                    end
                end else begin
                    queue_req(CMD_W'($urandom), LEVEL_W'($urandom));
                    n++;
                end
                // sender stops once until everything is answered
                if (p == 1 && !paused && n >= ITEMS_PER_PHASE / 2) begin
                    drain_pipeline();
                    paused = 1'b1;
                end
            end
            run_to_idle();
            quiet = 1'b0;
        end

        drain_pipeline();
        fail_count += wire_expect_q.size();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
sv/owbs_pkg.sv
sv/owbs_front.sv
sv/owbs_queue.sv
sv/owbs_back.sv
sv/one_wire_backlight_serializer.sv
sim/one_wire_backlight_serializer_tb.sv
